/* rtl/core/sek_pkg.sv */
// Shared types and codes of the stack engine.
package sek_pkg;

  localparam int DATA_W  = 32;
  localparam int COUNT_W = 7;

  typedef enum logic [3:0] {
    OP_PUSH        = 4'd0,
    OP_POP         = 4'd1,
    OP_PUSH_BOTTOM = 4'd2,
    OP_POP_BOTTOM  = 4'd3,
    OP_SORT_ASC    = 4'd4,
    OP_SORT_DESC   = 4'd5,
    OP_REVERSE     = 4'd6,
    OP_DEDUPE      = 4'd7,
    OP_QUERY       = 4'd8
  } op_e;

  typedef enum logic [4:0] {
    CMD_IDLE,
    CMD_PUSH_TOP,
    CMD_PUSH_BOT,
    CMD_OVERFLOW,
    CMD_EMPTY,
    CMD_REPORT,
    CMD_POP_TOP,
    CMD_POP_BOT,
    CMD_POP_DONE,
    CMD_SORT_UP,
    CMD_SORT_DOWN,
    CMD_SORT_PASS,
    CMD_SORT_LOAD,
    CMD_SORT_STEP,
    CMD_SORT_END,
    CMD_REV_START,
    CMD_REV_LO,
    CMD_REV_HI,
    CMD_REV_WLO,
    CMD_REV_WHI,
    CMD_DD_START,
    CMD_DD_RD,
    CMD_DD_LOAD,
    CMD_DD_CMP,
    CMD_DD_KEEP,
    CMD_DD_NEXT,
    CMD_DD_FIN
  } cmd_e;

  typedef struct packed {
    logic slot_free;
    logic full;
    logic empty;
    logic under_two;
    logic sort_last;
    logic sort_done;
    logic rev_more;
    logic dd_none;
    logic dd_match;
    logic dd_klast;
    logic dd_izero;
  } status_t;

  typedef struct packed {
    logic [3:0]               operation;
    logic signed [DATA_W-1:0] push_value;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic                     was_empty;
    logic                     overflow;
    logic [COUNT_W-1:0]       entry_count;
    logic signed [DATA_W-1:0] entry_sum;
  } result_t;

endpackage

/* rtl/core/stack_engine_with_bulk_ops.sv */
// Top level of the stack engine with bulk operations.
// A bounded LIFO of signed words kept in a circular store with one write and one registered
// read port, so bottom pushes and pops move a base pointer instead of the data. Push, bottom
// push, query and every refused or empty operation load their result in the cycle they are
// accepted; pops first read the store and load the result from the pop wait state. Sort,
// reverse and dedupe walk the store through its write and read ports, stepped by the sequencer.
// One result is returned per transaction, registered, and a new transaction is taken while it
// waits only when it is being taken in the same cycle.
module stack_engine_with_bulk_ops #(
  parameter int DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  sek_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output sek_pkg::result_t result
);

  sek_pkg::cmd_e    cmd;
  sek_pkg::status_t status;

  sek_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .operation  (item.operation),
    .status     (status),
    .item_ready (item_ready),
    .cmd        (cmd)
  );

  sek_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .push_value   (item.push_value),
    .result_ready (result_ready),
    .status       (status),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

/* rtl/core/sek_ctrl.sv */
// Sequencing state machine of the stack engine.
module sek_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic [3:0]         operation,
  input  sek_pkg::status_t   status,
  output logic               item_ready,
  output sek_pkg::cmd_e      cmd
);

  typedef enum logic [16:0] {
    ST_IDLE      = 17'h00001,
    ST_POP_WAIT  = 17'h00002,
    ST_SORT_LOAD = 17'h00004,
    ST_SORT_STEP = 17'h00008,
    ST_SORT_END  = 17'h00010,
    ST_SORT_PASS = 17'h00020,
    ST_REV_LO    = 17'h00040,
    ST_REV_HI    = 17'h00080,
    ST_REV_WLO   = 17'h00100,
    ST_REV_WHI   = 17'h00200,
    ST_DD_RD     = 17'h00400,
    ST_DD_LOAD   = 17'h00800,
    ST_DD_CMP    = 17'h01000,
    ST_DD_KEEP   = 17'h02000,
    ST_DD_NEXT   = 17'h04000,
    ST_DD_FIN    = 17'h08000,
    ST_FINISH    = 17'h10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign item_ready = (state == ST_IDLE) && status.slot_free;
  assign accept     = item_valid && item_ready;

  always_comb begin
    state_next = state;
    cmd        = sek_pkg::CMD_IDLE;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (operation)
            sek_pkg::OP_PUSH: begin
              cmd = status.full ? sek_pkg::CMD_OVERFLOW : sek_pkg::CMD_PUSH_TOP;
            end
            sek_pkg::OP_PUSH_BOTTOM: begin
              cmd = status.full ? sek_pkg::CMD_OVERFLOW : sek_pkg::CMD_PUSH_BOT;
            end
            sek_pkg::OP_POP: begin
              if (status.empty) begin
                cmd = sek_pkg::CMD_EMPTY;
              end else begin
                cmd        = sek_pkg::CMD_POP_TOP;
                state_next = ST_POP_WAIT;
              end
            end
            sek_pkg::OP_POP_BOTTOM: begin
              if (status.empty) begin
                cmd = sek_pkg::CMD_EMPTY;
              end else begin
                cmd        = sek_pkg::CMD_POP_BOT;
                state_next = ST_POP_WAIT;
              end
            end
            sek_pkg::OP_SORT_ASC: begin
              if (status.under_two) begin
                cmd = sek_pkg::CMD_REPORT;
              end else begin
                cmd        = sek_pkg::CMD_SORT_DOWN;
                state_next = ST_SORT_LOAD;
              end
            end
            sek_pkg::OP_SORT_DESC: begin
              if (status.under_two) begin
                cmd = sek_pkg::CMD_REPORT;
              end else begin
                cmd        = sek_pkg::CMD_SORT_UP;
                state_next = ST_SORT_LOAD;
              end
            end
            sek_pkg::OP_REVERSE: begin
              if (status.under_two) begin
                cmd = sek_pkg::CMD_REPORT;
              end else begin
                cmd        = sek_pkg::CMD_REV_START;
                state_next = ST_REV_LO;
              end
            end
            sek_pkg::OP_DEDUPE: begin
              if (status.under_two) begin
                cmd = sek_pkg::CMD_REPORT;
              end else begin
                cmd        = sek_pkg::CMD_DD_START;
                state_next = ST_DD_RD;
              end
            end
            default: begin
              cmd = sek_pkg::CMD_REPORT;
            end
          endcase
        end
      end
      ST_POP_WAIT: begin
        cmd        = sek_pkg::CMD_POP_DONE;
        state_next = ST_IDLE;
      end
      ST_SORT_LOAD: begin
        cmd        = sek_pkg::CMD_SORT_LOAD;
        state_next = ST_SORT_STEP;
      end
      ST_SORT_STEP: begin
        cmd = sek_pkg::CMD_SORT_STEP;
        if (status.sort_last) begin
          state_next = ST_SORT_END;
        end
      end
      ST_SORT_END: begin
        cmd        = sek_pkg::CMD_SORT_END;
        state_next = status.sort_done ? ST_FINISH : ST_SORT_PASS;
      end
      ST_SORT_PASS: begin
        cmd        = sek_pkg::CMD_SORT_PASS;
        state_next = ST_SORT_LOAD;
      end
      ST_REV_LO: begin
        cmd        = sek_pkg::CMD_REV_LO;
        state_next = ST_REV_HI;
      end
      ST_REV_HI: begin
        cmd        = sek_pkg::CMD_REV_HI;
        state_next = ST_REV_WLO;
      end
      ST_REV_WLO: begin
        cmd        = sek_pkg::CMD_REV_WLO;
        state_next = ST_REV_WHI;
      end
      ST_REV_WHI: begin
        cmd        = sek_pkg::CMD_REV_WHI;
        state_next = status.rev_more ? ST_REV_LO : ST_FINISH;
      end
      ST_DD_RD: begin
        cmd        = sek_pkg::CMD_DD_RD;
        state_next = ST_DD_LOAD;
      end
      ST_DD_LOAD: begin
        cmd        = sek_pkg::CMD_DD_LOAD;
        state_next = status.dd_none ? ST_DD_KEEP : ST_DD_CMP;
      end
      ST_DD_CMP: begin
        cmd = sek_pkg::CMD_DD_CMP;
        if (status.dd_match) begin
          state_next = ST_DD_NEXT;
        end else if (status.dd_klast) begin
          state_next = ST_DD_KEEP;
        end
      end
      ST_DD_KEEP: begin
        cmd        = sek_pkg::CMD_DD_KEEP;
        state_next = ST_DD_NEXT;
      end
      ST_DD_NEXT: begin
        cmd        = sek_pkg::CMD_DD_NEXT;
        state_next = status.dd_izero ? ST_DD_FIN : ST_DD_RD;
      end
      ST_DD_FIN: begin
        cmd        = sek_pkg::CMD_DD_FIN;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        cmd        = sek_pkg::CMD_REPORT;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/core/sek_datapath.sv */
// Storage, pointers, sum and result register of the stack engine.
module sek_datapath #(
  parameter int DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  sek_pkg::cmd_e                     cmd,
  input  logic signed [sek_pkg::DATA_W-1:0] push_value,
  input  logic                              result_ready,
  output sek_pkg::status_t                  status,
  output logic                              result_valid,
  output sek_pkg::result_t                  result
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int DW = sek_pkg::DATA_W;

  logic [DW-1:0]        mem [DEPTH];
  logic signed [DW-1:0] rd;
  logic [AW-1:0]        raddr;
  logic [AW-1:0]        waddr;
  logic signed [DW-1:0] wdata;
  logic                 we;

  logic [AW-1:0]        base;
  logic [CW-1:0]        cnt;
  logic signed [DW-1:0] sum;
  logic signed [DW-1:0] hold;
  logic signed [DW-1:0] nsum;
  logic [CW-1:0]        ia;
  logic [CW-1:0]        ib;
  logic [CW-1:0]        ic;
  logic                 dir;
  logic                 go_up;
  logic                 load_res;
  sek_pkg::result_t     result_next;

  // Logical index from the bottom to a location in the circular store.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] b, input logic [CW-1:0] l);
    logic [CW:0] s;
    s = (CW+1)'(b) + (CW+1)'(l);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign go_up = dir ? (hold > rd) : (hold < rd);

  assign status.slot_free = !result_valid || result_ready;
  assign status.full      = (cnt == CW'(DEPTH));
  assign status.empty     = (cnt == '0);
  assign status.under_two = (cnt < CW'(2));
  assign status.sort_last = ((ia + CW'(1)) == cnt);
  assign status.sort_done = ((ib + CW'(2)) == cnt);
  assign status.rev_more  = ((ia + CW'(2)) < ib);
  assign status.dd_none   = (ib == cnt);
  assign status.dd_match  = (rd == hold);
  assign status.dd_klast  = ((ic + CW'(1)) == cnt);
  assign status.dd_izero  = (ia == '0);

  always_comb begin
    we    = 1'b0;
    waddr = base;
    wdata = hold;
    raddr = base;
    unique case (cmd)
      sek_pkg::CMD_PUSH_TOP: begin
        we    = 1'b1;
        waddr = phys(base, cnt);
        wdata = push_value;
      end
      sek_pkg::CMD_PUSH_BOT: begin
        we    = 1'b1;
        waddr = phys(base, CW'(DEPTH - 1));
        wdata = push_value;
      end
      sek_pkg::CMD_POP_TOP: raddr = phys(base, cnt - CW'(1));
      sek_pkg::CMD_SORT_LOAD: raddr = phys(base, ia);
      sek_pkg::CMD_SORT_STEP: begin
        we    = 1'b1;
        waddr = phys(base, ia - CW'(1));
        wdata = go_up ? rd : hold;
        raddr = phys(base, ia + CW'(1));
      end
      sek_pkg::CMD_SORT_END: begin
        we    = 1'b1;
        waddr = phys(base, cnt - CW'(1));
      end
      sek_pkg::CMD_REV_LO: raddr = phys(base, ia);
      sek_pkg::CMD_REV_HI: raddr = phys(base, ib);
      sek_pkg::CMD_REV_WLO: begin
        we    = 1'b1;
        waddr = phys(base, ia);
        wdata = rd;
      end
      sek_pkg::CMD_REV_WHI: begin
        we    = 1'b1;
        waddr = phys(base, ib);
      end
      sek_pkg::CMD_DD_RD: raddr = phys(base, ia);
      sek_pkg::CMD_DD_LOAD: raddr = phys(base, ib);
      sek_pkg::CMD_DD_CMP: raddr = phys(base, ic + CW'(1));
      sek_pkg::CMD_DD_KEEP: begin
        we    = 1'b1;
        waddr = phys(base, ib - CW'(1));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd <= mem[raddr];
  end

  always_comb begin
    load_res                = 1'b0;
    result_next.data_out    = '0;
    result_next.was_empty   = 1'b0;
    result_next.overflow    = 1'b0;
    result_next.entry_count = sek_pkg::COUNT_W'(cnt);
    result_next.entry_sum   = sum;
    unique case (cmd)
      sek_pkg::CMD_PUSH_TOP, sek_pkg::CMD_PUSH_BOT: begin
        load_res                = 1'b1;
        result_next.entry_count = sek_pkg::COUNT_W'(cnt + CW'(1));
        result_next.entry_sum   = sum + push_value;
      end
      sek_pkg::CMD_OVERFLOW: begin
        load_res             = 1'b1;
        result_next.overflow = 1'b1;
      end
      sek_pkg::CMD_EMPTY: begin
        load_res              = 1'b1;
        result_next.was_empty = 1'b1;
      end
      sek_pkg::CMD_POP_DONE: begin
        load_res              = 1'b1;
        result_next.data_out  = rd;
        result_next.entry_sum = sum - rd;
      end
      sek_pkg::CMD_REPORT: load_res = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base         <= '0;
      cnt          <= '0;
      sum          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (load_res) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (cmd)
        sek_pkg::CMD_PUSH_TOP: begin
          cnt <= cnt + CW'(1);
          sum <= sum + push_value;
        end
        sek_pkg::CMD_PUSH_BOT: begin
          base <= phys(base, CW'(DEPTH - 1));
          cnt  <= cnt + CW'(1);
          sum  <= sum + push_value;
        end
        sek_pkg::CMD_POP_TOP: cnt <= cnt - CW'(1);
        sek_pkg::CMD_POP_BOT: begin
          base <= phys(base, CW'(1));
          cnt  <= cnt - CW'(1);
        end
        sek_pkg::CMD_POP_DONE: sum <= sum - rd;
        sek_pkg::CMD_DD_FIN: begin
          base <= phys(base, ib);
          cnt  <= cnt - ib;
          sum  <= nsum;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      result <= result_next;
    end
    unique case (cmd)
      sek_pkg::CMD_SORT_UP, sek_pkg::CMD_SORT_DOWN: begin
        dir <= (cmd == sek_pkg::CMD_SORT_UP);
        ia  <= CW'(1);
        ib  <= '0;
      end
      sek_pkg::CMD_SORT_PASS: ia <= CW'(1);
      sek_pkg::CMD_SORT_LOAD: hold <= rd;
      sek_pkg::CMD_SORT_STEP: begin
        ia <= ia + CW'(1);
        if (!go_up) begin
          hold <= rd;
        end
      end
      sek_pkg::CMD_SORT_END: ib <= ib + CW'(1);
      sek_pkg::CMD_REV_START: begin
        ia <= '0;
        ib <= cnt - CW'(1);
      end
      sek_pkg::CMD_REV_HI: hold <= rd;
      sek_pkg::CMD_REV_WHI: begin
        ia <= ia + CW'(1);
        ib <= ib - CW'(1);
      end
      sek_pkg::CMD_DD_START: begin
        ia   <= cnt - CW'(1);
        ib   <= cnt;
        nsum <= '0;
      end
      sek_pkg::CMD_DD_LOAD: begin
        hold <= rd;
        ic   <= ib;
      end
      sek_pkg::CMD_DD_CMP: ic <= ic + CW'(1);
      sek_pkg::CMD_DD_KEEP: begin
        ib   <= ib - CW'(1);
        nsum <= nsum + hold;
      end
      sek_pkg::CMD_DD_NEXT: ia <= ia - CW'(1);
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= CW'(DEPTH))
    else $error("Entry count exceeds the store depth.");
  a_base_bound: assert property (@(posedge clk) disable iff (rst) base <= AW'(DEPTH - 1))
    else $error("Base pointer left the store.");
  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    load_res |-> (!result_valid || result_ready))
    else $error("Result loaded over a transaction not yet taken.");
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    cmd == sek_pkg::CMD_PUSH_TOP |=> cnt == CW'($past(cnt) + CW'(1)))
    else $error("Push did not advance the entry count.");
`endif

endmodule

/* bench/stack_engine_with_bulk_ops_tb.sv */
// Self-checking testbench for the stack engine with bulk operations.
module stack_engine_with_bulk_ops_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY = 64;
  localparam int STALL_LIMIT = 20000;
  localparam logic [3:0] OP_UNUSED_LO = 4'd9;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_ready;
  sek_pkg::item_t item;
  logic result_valid;
  logic result_ready;
  sek_pkg::result_t result;

  logic signed [sek_pkg::DATA_W-1:0] model_store[CAPACITY];
  int unsigned model_count;
  logic signed [sek_pkg::DATA_W-1:0] model_sum;
  sek_pkg::result_t pending_results[$];
  int unsigned fail_count;
  int unsigned quiet_cycles;
  bit sender_gaps;
  bit receiver_gaps;
  bit long_hold;

  stack_engine_with_bulk_ops #(.DEPTH(CAPACITY)) u_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void sort_model(bit smallest_on_top);
    logic signed [sek_pkg::DATA_W-1:0] v;
    int j;
    bit move;
    for (int i = 1; i < model_count; i++) begin
      v = model_store[i];
      j = i;
      while (j > 0) begin
        move = smallest_on_top ? (model_store[j-1] < v) : (model_store[j-1] > v);
        if (!move) break;
        model_store[j] = model_store[j-1];
        j--;
      end
      model_store[j] = v;
    end
  endfunction

  function automatic void dedupe_model();
    logic signed [sek_pkg::DATA_W-1:0] kept[$];
    bit seen;
    for (int i = model_count - 1; i >= 0; i--) begin
      seen = 1'b0;
      foreach (kept[k]) if (kept[k] == model_store[i]) seen = 1'b1;
      if (!seen) kept.push_back(model_store[i]);
    end
    model_count = kept.size();
    model_sum = '0;
    for (int i = 0; i < model_count; i++) begin
      model_store[i] = kept[model_count - 1 - i];
      model_sum += model_store[i];
    end
  endfunction

  function automatic sek_pkg::result_t predict_stack(sek_pkg::item_t t);
    sek_pkg::result_t r;
    logic signed [sek_pkg::DATA_W-1:0] tmp;
    r = '0;
    case (t.operation)
      sek_pkg::OP_PUSH, sek_pkg::OP_PUSH_BOTTOM: begin
        if (model_count >= CAPACITY) begin
          r.overflow = 1'b1;
        end else begin
          if (t.operation == sek_pkg::OP_PUSH) begin
            model_store[model_count] = t.push_value;
          end else begin
            for (int i = model_count; i > 0; i--) model_store[i] = model_store[i-1];
            model_store[0] = t.push_value;
          end
          model_count++;
          model_sum += t.push_value;
        end
      end
      sek_pkg::OP_POP, sek_pkg::OP_POP_BOTTOM: begin
        if (model_count == 0) begin
          r.was_empty = 1'b1;
        end else begin
          if (t.operation == sek_pkg::OP_POP) begin
            r.data_out = model_store[model_count-1];
          end else begin
            r.data_out = model_store[0];
            for (int i = 0; i + 1 < model_count; i++) model_store[i] = model_store[i+1];
          end
          model_count--;
          model_sum -= r.data_out;
        end
      end
      sek_pkg::OP_SORT_ASC: sort_model(1'b1);
      sek_pkg::OP_SORT_DESC: sort_model(1'b0);
      sek_pkg::OP_REVERSE: begin
        for (int i = 0; i < model_count / 2; i++) begin
          tmp = model_store[i];
          model_store[i] = model_store[model_count-1-i];
          model_store[model_count-1-i] = tmp;
        end
      end
      sek_pkg::OP_DEDUPE: dedupe_model();
      default: ;
    endcase
    r.entry_count = model_count[sek_pkg::COUNT_W-1:0];
    r.entry_sum = model_sum;
    return r;
  endfunction

  task automatic send_item(logic [3:0] op, logic signed [sek_pkg::DATA_W-1:0] value);
    int gap;
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= '{operation: op, push_value: value};
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    pending_results.push_back(predict_stack('{operation: op, push_value: value}));
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [sek_pkg::DATA_W-1:0] random_word();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom_range(0, 7) - 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed_edges();
    send_item(sek_pkg::OP_POP, 0);
    send_item(sek_pkg::OP_POP_BOTTOM, 0);
    send_item(sek_pkg::OP_SORT_ASC, 0);
    send_item(sek_pkg::OP_REVERSE, 0);
    send_item(sek_pkg::OP_DEDUPE, 0);
    send_item(sek_pkg::OP_PUSH, 32'sh7fffffff);
    send_item(sek_pkg::OP_SORT_DESC, 0);
    send_item(sek_pkg::OP_PUSH, 32'sh80000000);
    send_item(sek_pkg::OP_PUSH_BOTTOM, 32'sh7fffffff);
    send_item(sek_pkg::OP_PUSH, -1);
    send_item(sek_pkg::OP_PUSH, 0);
    send_item(sek_pkg::OP_SORT_ASC, 0);
    send_item(sek_pkg::OP_SORT_DESC, 0);
    send_item(sek_pkg::OP_REVERSE, 0);
    send_item(sek_pkg::OP_DEDUPE, 0);
    send_item(sek_pkg::OP_QUERY, 0);
    send_item(OP_UNUSED_LO, 32'sh12345678);
    send_item(OP_UNUSED_HI, 0);
    send_item(sek_pkg::OP_POP, 0);
    send_item(sek_pkg::OP_POP_BOTTOM, 0);
    send_item(sek_pkg::OP_POP, 0);
    send_item(sek_pkg::OP_POP, 0);
    send_item(sek_pkg::OP_POP, 0);
  endtask

  task automatic test_full_stack();
    for (int i = 0; i < CAPACITY; i++) send_item(sek_pkg::OP_PUSH, random_word());
    send_item(sek_pkg::OP_PUSH, 32'sh5a5a5a5a);
    send_item(sek_pkg::OP_PUSH_BOTTOM, -7);
    send_item(sek_pkg::OP_SORT_ASC, 0);
    send_item(sek_pkg::OP_REVERSE, 0);
    send_item(sek_pkg::OP_DEDUPE, 0);
    while (model_count > 0) begin
      send_item($urandom_range(0, 1) ? sek_pkg::OP_POP : sek_pkg::OP_POP_BOTTOM, 0);
    end
  endtask

  task automatic test_backpressure();
    long_hold = 1'b1;
    for (int i = 0; i < 12; i++) send_item(sek_pkg::OP_PUSH, random_word());
    wait_drained();
    wait (!long_hold);
  endtask

  task automatic test_random_mix(int n);
    logic [3:0] op;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) op = sek_pkg::OP_PUSH;
      else if (pick < 45) op = sek_pkg::OP_PUSH_BOTTOM;
      else if (pick < 60) op = sek_pkg::OP_POP;
      else if (pick < 68) op = sek_pkg::OP_POP_BOTTOM;
      else if (pick < 96) op = 4'($urandom_range(sek_pkg::OP_SORT_ASC, sek_pkg::OP_QUERY));
      else op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      send_item(op, random_word());
      if (i % 97 == 96) wait_drained();
    end
  endtask

  initial begin
    int hold;
    result_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        result_ready <= 1'b0;
        hold = 0;
        while (hold < 150) begin
          @(posedge clk);
          hold++;
        end
        long_hold = 1'b0;
      end else if (receiver_gaps && $urandom_range(0, 4) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 5) - 1) @(posedge clk);
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    sek_pkg::result_t exp_r;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction");
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (result.data_out !== exp_r.data_out) begin
          $error("data_out expected %0d got %0d", exp_r.data_out, result.data_out);
          fail_count++;
        end
        if (result.was_empty !== exp_r.was_empty) begin
          $error("was_empty expected %0b got %0b", exp_r.was_empty, result.was_empty);
          fail_count++;
        end
        if (result.overflow !== exp_r.overflow) begin
          $error("overflow expected %0b got %0b", exp_r.overflow, result.overflow);
          fail_count++;
        end
        if (result.entry_count !== exp_r.entry_count) begin
          $error("entry_count expected %0d got %0d", exp_r.entry_count, result.entry_count);
          fail_count++;
        end
        if (result.entry_sum !== exp_r.entry_sum) begin
          $error("entry_sum expected %0d got %0d", exp_r.entry_sum, result.entry_sum);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    fail_count = 0;
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
    long_hold = 1'b0;
    model_count = 0;
    model_sum = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_edges();
    test_full_stack();
    wait_drained();
    test_backpressure();
    test_random_mix(200);
    wait_drained();
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    test_random_mix(80);
    wait_drained();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
